/* design/dated_rate_table_floor_lookup_macros.svh */
// Assertion helpers shared by the checker.
`ifndef DATED_RATE_TABLE_FLOOR_LOOKUP_MACROS_SVH
`define DATED_RATE_TABLE_FLOOR_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DRTFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DRTFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/drtfl_pkg.sv */
package drtfl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 7;
    localparam int DAY_W       = 7;
    localparam int KEY_W       = YEAR_W + MONTH_W + DAY_W;
    localparam int RATE_W      = 32;
    localparam int STATUS_W    = 3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXACT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EARLIER   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTHS  = 7'd12;

    // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  CENTURY      = 7'd100;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_PROBE_WAIT,
        S_PREV_WAIT,
        S_SHIFT,
        S_WRITE
    } state_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 7'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    d = 7'd30;
            7'd2:                                       d = leap ? 7'd29 : 7'd28;
            default:                                    d = 7'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/dated_rate_table_floor_lookup.sv */
// Sorted date/rate table with floor lookup. Pulse start while busy is low to
// hand over one item; exactly one result follows, valid for the single cycle
// in which done is high, and it must be captured then as the block cannot be
// stalled. All work runs through one table memory with one read and one
// write port and a registered read. A lookup runs a binary search over the
// stored entries and then probes the found slot, with one more read when the
// result is an earlier date; an insert runs the same search, then moves each
// entry above the insertion point up by one and writes the new entry. busy
// falls as done rises.
module dated_rate_table_floor_lookup (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                mode,
    input  logic [drtfl_pkg::YEAR_W-1:0]        year,
    input  logic [drtfl_pkg::MONTH_W-1:0]       month,
    input  logic [drtfl_pkg::DAY_W-1:0]         day,
    input  logic signed [drtfl_pkg::RATE_W-1:0] rate_in,
    output logic [drtfl_pkg::STATUS_W-1:0]      status,
    output logic                                table_full,
    output logic signed [drtfl_pkg::RATE_W-1:0] rate_out
);

    logic [drtfl_pkg::KEY_W-1:0] key;
    logic                        date_ok;
    drtfl_pkg::mem_req_t         req;
    drtfl_pkg::entry_t           rdata;

    drtfl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .done       (done),
        .mode       (mode),
        .year       (year),
        .month      (month),
        .day        (day),
        .rate_in    (rate_in),
        .status     (status),
        .table_full (table_full),
        .rate_out   (rate_out),
        .key        (key),
        .date_ok    (date_ok),
        .req        (req),
        .rdata      (rdata)
    );

    drtfl_date_check u_date (
        .clk     (clk),
        .key     (key),
        .date_ok (date_ok)
    );

    drtfl_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule

/* design/drtfl_store.sv */
module drtfl_store (
    input  logic                clk,
    input  drtfl_pkg::mem_req_t req,
    output drtfl_pkg::entry_t   rdata
);

    drtfl_pkg::entry_t mem_array [drtfl_pkg::TABLE_DEPTH];
    drtfl_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_array[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem_array[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/drtfl_date_check.sv */
module drtfl_date_check (
    input  logic                           clk,
    input  logic [drtfl_pkg::KEY_W-1:0]    key,
    output logic                           date_ok
);

    logic [drtfl_pkg::YEAR_W-1:0]  year;
    logic [drtfl_pkg::MONTH_W-1:0] month;
    logic [drtfl_pkg::DAY_W-1:0]   day;
    logic [drtfl_pkg::YEAR_W+12:0] prod;
    logic [7:0]                    cent_next;
    logic [7:0]                    cent_reg;
    logic [14:0]                   back;
    logic                          div100;
    logic                          div400;
    logic                          leap;
    logic [drtfl_pkg::DAY_W-1:0]   lim;

    assign year  = key[drtfl_pkg::KEY_W-1 -: drtfl_pkg::YEAR_W];
    assign month = key[drtfl_pkg::MONTH_W+drtfl_pkg::DAY_W-1 -: drtfl_pkg::MONTH_W];
    assign day   = key[drtfl_pkg::DAY_W-1:0];

    // century count, registered; key is held for the whole item
    assign prod      = year * drtfl_pkg::DIV100_MUL;
    assign cent_next = prod[drtfl_pkg::DIV100_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        cent_reg <= cent_next;
    end

    assign back   = cent_reg * drtfl_pkg::CENTURY;
    assign div100 = (back == {1'b0, year});
    assign div400 = div100 && (cent_reg[1:0] == 2'b00);
    assign leap   = ((year[1:0] == 2'b00) && !div100) || div400;
    assign lim    = drtfl_pkg::month_days(month, leap);

    assign date_ok = (year <= drtfl_pkg::YEAR_MAX) && (month != '0)
                  && (month <= drtfl_pkg::MONTHS) && (day != '0) && (day <= lim);

endmodule

/* design/drtfl_ctrl.sv */
module drtfl_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                mode,
    input  logic [drtfl_pkg::YEAR_W-1:0]        year,
    input  logic [drtfl_pkg::MONTH_W-1:0]       month,
    input  logic [drtfl_pkg::DAY_W-1:0]         day,
    input  logic signed [drtfl_pkg::RATE_W-1:0] rate_in,
    output logic [drtfl_pkg::STATUS_W-1:0]      status,
    output logic                                table_full,
    output logic signed [drtfl_pkg::RATE_W-1:0] rate_out,
    output logic [drtfl_pkg::KEY_W-1:0]         key,
    input  logic                                date_ok,
    output drtfl_pkg::mem_req_t                 req,
    input  drtfl_pkg::entry_t                   rdata
);

    drtfl_pkg::state_t state_reg, state_next;
    logic [drtfl_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [drtfl_pkg::CNT_W-1:0]    lo_reg, lo_next;
    logic [drtfl_pkg::CNT_W-1:0]    hi_reg, hi_next;
    logic [drtfl_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                           mode_reg, mode_next;
    logic [drtfl_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [drtfl_pkg::RATE_W-1:0]   rate_reg, rate_next;
    logic                           done_reg, done_next;
    logic [drtfl_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                           full_reg, full_next;
    logic [drtfl_pkg::RATE_W-1:0]   rout_reg, rout_next;

    logic [drtfl_pkg::CNT_W-1:0]    mid;
    logic [drtfl_pkg::CNT_W-1:0]    lo_m1;
    logic [drtfl_pkg::CNT_W-1:0]    cnt_m1;
    logic [drtfl_pkg::IDX_W-1:0]    idx_m1;
    logic                           exact;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_m1  = lo_reg - 1'b1;
    assign cnt_m1 = count_reg - 1'b1;
    assign idx_m1 = idx_reg - 1'b1;
    assign exact  = (lo_reg < count_reg) && (rdata.key == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= drtfl_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        rate_reg   <= rate_next;
        status_reg <= status_next;
        full_reg   <= full_next;
        rout_reg   <= rout_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        rate_next   = rate_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        full_next   = full_reg;
        rout_next   = rout_reg;
        req.we      = 1'b0;
        req.waddr   = idx_reg;
        req.wdata   = rdata;
        req.raddr   = mid[drtfl_pkg::IDX_W-1:0];

        case (state_reg)
            drtfl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    key_next   = {year, month, day};
                    rate_next  = rate_in;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = drtfl_pkg::S_SEARCH;
                end
            end
            drtfl_pkg::S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = drtfl_pkg::S_COMPARE;
                end
                else
                begin
                    req.raddr  = lo_reg[drtfl_pkg::IDX_W-1:0];
                    state_next = drtfl_pkg::S_PROBE_WAIT;
                end
            end
            drtfl_pkg::S_COMPARE:
            begin
                if (rdata.key < key_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = drtfl_pkg::S_SEARCH;
            end
            drtfl_pkg::S_PROBE_WAIT:
            begin
                if (mode_reg)
                begin
                    if (exact)
                    begin
                        done_next   = 1'b1;
                        status_next = drtfl_pkg::ST_EXACT;
                        full_next   = 1'b0;
                        rout_next   = rdata.rate;
                        state_next  = drtfl_pkg::S_IDLE;
                    end
                    else if (lo_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = drtfl_pkg::ST_NONE;
                        full_next   = 1'b0;
                        rout_next   = '0;
                        state_next  = drtfl_pkg::S_IDLE;
                    end
                    else
                    begin
                        req.raddr  = lo_m1[drtfl_pkg::IDX_W-1:0];
                        state_next = drtfl_pkg::S_PREV_WAIT;
                    end
                end
                else
                begin
                    if (!date_ok)
                    begin
                        done_next   = 1'b1;
                        status_next = drtfl_pkg::ST_INVALID;
                        full_next   = 1'b0;
                        rout_next   = '0;
                        state_next  = drtfl_pkg::S_IDLE;
                    end
                    else if (exact)
                    begin
                        done_next   = 1'b1;
                        status_next = drtfl_pkg::ST_DUPLICATE;
                        full_next   = 1'b0;
                        rout_next   = '0;
                        state_next  = drtfl_pkg::S_IDLE;
                    end
                    else if (count_reg >= drtfl_pkg::CNT_W'(drtfl_pkg::TABLE_DEPTH))
                    begin
                        done_next   = 1'b1;
                        status_next = drtfl_pkg::ST_NONE;
                        full_next   = 1'b1;
                        rout_next   = '0;
                        state_next  = drtfl_pkg::S_IDLE;
                    end
                    else if (count_reg > lo_reg)
                    begin
                        req.raddr  = cnt_m1[drtfl_pkg::IDX_W-1:0];
                        idx_next   = count_reg[drtfl_pkg::IDX_W-1:0];
                        state_next = drtfl_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = drtfl_pkg::S_WRITE;
                    end
                end
            end
            drtfl_pkg::S_PREV_WAIT:
            begin
                done_next   = 1'b1;
                status_next = drtfl_pkg::ST_EARLIER;
                full_next   = 1'b0;
                rout_next   = rdata.rate;
                state_next  = drtfl_pkg::S_IDLE;
            end
            drtfl_pkg::S_SHIFT:
            begin
                // move entry idx-1 up to idx while fetching idx-2
                req.we    = 1'b1;
                req.waddr = idx_reg;
                req.wdata = rdata;
                if (drtfl_pkg::CNT_W'(idx_m1) > lo_reg)
                begin
                    req.raddr = idx_m1 - 1'b1;
                    idx_next  = idx_m1;
                end
                else
                begin
                    state_next = drtfl_pkg::S_WRITE;
                end
            end
            drtfl_pkg::S_WRITE:
            begin
                req.we      = 1'b1;
                req.waddr   = lo_reg[drtfl_pkg::IDX_W-1:0];
                req.wdata   = '{key: key_reg, rate: rate_reg};
                count_next  = count_reg + 1'b1;
                done_next   = 1'b1;
                status_next = drtfl_pkg::ST_INSERTED;
                full_next   = 1'b0;
                rout_next   = '0;
                state_next  = drtfl_pkg::S_IDLE;
            end
            default:
            begin
                state_next = drtfl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != drtfl_pkg::S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign table_full = full_reg;
    assign rate_out   = signed'(rout_reg);
    assign key        = key_reg;

endmodule

/* design/drtfl_checker.sv */
`include "dated_rate_table_floor_lookup_macros.svh"

module drtfl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                done,
    input logic [drtfl_pkg::STATUS_W-1:0]      status,
    input logic                                table_full,
    input logic signed [drtfl_pkg::RATE_W-1:0] rate_out
);

    logic st_none;
    logic st_match;

    // result ports hold their last item between strobes
    assign st_none  = (status == drtfl_pkg::ST_NONE);
    assign st_match = (status == drtfl_pkg::ST_EXACT) || (status == drtfl_pkg::ST_EARLIER);

    `DRTFL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `DRTFL_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `DRTFL_ASSERT_NEXT(a_single_result, done, !done, "more than one result for an item")
    `DRTFL_ASSERT_NOW(a_full_status, done && table_full, st_none, "full flag, wrong status")
    `DRTFL_ASSERT_NOW(a_rate_zero, done && !st_match, rate_out == '0, "rate on unmatched result")

endmodule

bind dated_rate_table_floor_lookup drtfl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .table_full (table_full),
    .rate_out   (rate_out)
);
